### hdl/gcx_pkg.sv
`default_nettype none
package gcx_pkg;

    localparam int FRAC_IN_W = 16;
    localparam int DIR_W     = 18;
    localparam int CFG_W     = 16;
    localparam int CFG_A_W   = 3;
    localparam int STEP_W    = 32;
    localparam int AXES      = 3;

    localparam logic [CFG_A_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_THR   = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_TAN   = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_SIN2  = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_ROUND = 3'd4;

    typedef logic [DIR_W-1:0]  t_mag;
    typedef logic [STEP_W-1:0] t_step;

endpackage
`default_nettype wire

### hdl/grid_cell_exit_step.sv
`default_nettype none
// Computes the distance along a direction vector from a point inside a unit grid cell to the
// face where the ray leaves the cell, plus a programmable roundoff step, in Q16.16 with
// saturation. A request is accepted every cycle unless the result side stalls the pipeline.
// The pipeline holds a restoring divider, which resolves one quotient bit per stage for each
// of the three axes in parallel. Backpressure on the result side stalls the whole pipeline.
// Configuration must be written only while no request is in flight.
module grid_cell_exit_step #(
    parameter int FRAC_BITS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // frac_x, frac_y, frac_z, dir_x, dir_y, dir_z, zero padding
    input  wire  [103:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // step_length
    output logic [31:0]  o_m_axis_tdata,
    // degenerate
    output logic [0:0]   o_m_axis_tuser,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [gcx_pkg::CFG_A_W-1:0] i_cfg_addr,
    input  wire  [gcx_pkg::CFG_W-1:0]   i_cfg_data
);
    import gcx_pkg::*;

    localparam int NDIV = STEP_W;
    localparam int LAST = NDIV + 3;
    localparam int NW   = 2 * FRAC_BITS + 51;
    localparam int HW   = NW - STEP_W;
    localparam int TPW  = CFG_W + DIR_W;
    localparam int SQW  = 2 * DIR_W;
    localparam int NRW  = SQW + 2;
    localparam int LMW  = NRW + CFG_W;

    logic             r_mode;
    logic [CFG_W-1:0] r_thr, r_tan, r_sin2, r_round;

    logic             ce;
    logic [LAST:0]    r_v;

    logic [FRAC_BITS:0] r_n [AXES];
    t_mag               r_m [AXES];

    logic [DIR_W-1:0]  r_rem [0:NDIV][AXES];
    logic [STEP_W-1:0] r_qt  [0:NDIV][AXES];
    logic [STEP_W-1:0] r_nl  [0:NDIV][AXES];
    t_mag              r_dm  [0:NDIV][AXES];
    logic              r_sat [0:NDIV][AXES];

    logic              r_sm [1:NDIV+1];
    logic [TPW-1:0]    r_tp [2];
    logic [SQW-1:0]    r_sq1 [AXES];
    logic [SQW-1:0]    r_sq2 [AXES];
    logic [SQW-1:0]    r_sq3 [AXES];
    logic [1:0]        r_q2 [2:3];
    logic [NRW-1:0]    r_nrm;
    logic [LMW-1:0]    r_lim;
    logic [AXES-1:0]   r_ql [4:NDIV+1];

    logic  r_any, r_small;
    t_step r_best;
    t_step r_out;
    logic  r_deg;

    logic [AXES-1:0]   n_ql;
    logic [DIR_W-1:0]  n_rem [1:NDIV][AXES];
    logic              n_bit [1:NDIV][AXES];
    logic [HW-1:0]     n_hi  [AXES];
    logic [NW-1:0]     n_full [AXES];
    logic              n_small;
    logic              n_any;
    t_step             n_best;
    t_step             n_ax [AXES];
    logic [STEP_W:0]   n_sum;

    assign ce              = !r_v[LAST] || i_m_axis_tready;
    assign o_s_axis_tready = ce;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_v[LAST];
    assign o_m_axis_tdata  = r_out;
    assign o_m_axis_tuser  = r_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b1;
            r_thr   <= 16'd1;
            r_tan   <= 16'd3280;
            r_sin2  <= 16'd164;
            r_round <= 16'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_MODE:  r_mode  <= i_cfg_data[0];
                REG_THR:   r_thr   <= i_cfg_data;
                REG_TAN:   r_tan   <= i_cfg_data;
                REG_SIN2:  r_sin2  <= i_cfg_data;
                REG_ROUND: r_round <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (ce) begin
            r_v <= {r_v[LAST-1:0], i_s_axis_tvalid};
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_full[a] = NW'(r_n[a]) << FRAC_BITS;
            n_hi[a]   = n_full[a][NW-1:STEP_W];
        end
        n_small = (r_m[0] < DIR_W'(r_thr)) && (r_m[1] < DIR_W'(r_thr))
                  && (!r_mode || (r_m[2] < DIR_W'(r_thr)));
        for (int k = 1; k <= NDIV; k++) begin
            for (int a = 0; a < AXES; a++) begin
                n_bit[k][a] = ({r_rem[k-1][a], r_nl[k-1][a][STEP_W-1]}
                               >= {1'b0, r_dm[k-1][a]});
                n_rem[k][a] = n_bit[k][a]
                    ? DIR_W'({r_rem[k-1][a], r_nl[k-1][a][STEP_W-1]} - {1'b0, r_dm[k-1][a]})
                    : DIR_W'({r_rem[k-1][a], r_nl[k-1][a][STEP_W-1]});
            end
        end
        for (int a = 0; a < AXES; a++) begin
            n_ql[a] = (LMW'(r_sq3[a]) > r_lim);
        end
        if (!r_mode) begin
            n_ql = {1'b0, r_q2[3]};
        end
        n_any  = 1'b0;
        n_best = '1;
        for (int a = 0; a < AXES; a++) begin
            n_ax[a] = r_sat[NDIV][a] ? '1 : r_qt[NDIV][a];
            if (r_ql[NDIV+1][a]) begin
                if (!n_any || n_ax[a] < n_best) begin
                    n_best = n_ax[a];
                end
                n_any = 1'b1;
            end
        end
        n_sum = {1'b0, r_best} + (STEP_W+1)'(r_round);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int a = 0; a < AXES; a++) begin
                if (i_s_axis_tdata[48 + DIR_W*a + DIR_W - 1]) begin
                    r_n[a] <= {1'b0, FRAC_BITS'(i_s_axis_tdata[FRAC_IN_W*a +: FRAC_IN_W])};
                    r_m[a] <= -i_s_axis_tdata[48 + DIR_W*a +: DIR_W];
                end else begin
                    r_n[a] <= ((FRAC_BITS+1)'(1) << FRAC_BITS)
                              - (FRAC_BITS+1)'(FRAC_BITS'(
                                  i_s_axis_tdata[FRAC_IN_W*a +: FRAC_IN_W]));
                    r_m[a] <= i_s_axis_tdata[48 + DIR_W*a +: DIR_W];
                end
                r_sat[0][a] <= (n_hi[a] >= HW'(r_m[a]));
                r_rem[0][a] <= n_hi[a][DIR_W-1:0];
                r_nl[0][a]  <= n_full[a][STEP_W-1:0];
                r_qt[0][a]  <= '0;
                r_dm[0][a]  <= r_m[a];
                r_sq1[a]    <= SQW'(r_m[a]) * SQW'(r_m[a]);
                r_sq2[a]    <= r_sq1[a];
                r_sq3[a]    <= r_sq2[a];
            end
            for (int k = 1; k <= NDIV; k++) begin
                for (int a = 0; a < AXES; a++) begin
                    r_rem[k][a] <= n_rem[k][a];
                    r_qt[k][a]  <= {r_qt[k-1][a][STEP_W-2:0], n_bit[k][a]};
                    r_nl[k][a]  <= r_nl[k-1][a] << 1;
                    r_dm[k][a]  <= r_dm[k-1][a];
                    r_sat[k][a] <= r_sat[k-1][a];
                end
            end
            r_tp[0] <= TPW'(r_tan) * TPW'(r_m[1]);
            r_tp[1] <= TPW'(r_tan) * TPW'(r_m[0]);
            r_sm[1] <= n_small;
            for (int s = 2; s <= NDIV + 1; s++) begin
                r_sm[s] <= r_sm[s-1];
            end
            r_q2[2][0] <= TPW'(r_dm[0][0]) > (r_tp[0] >> FRAC_BITS);
            r_q2[2][1] <= TPW'(r_dm[0][1]) > (r_tp[1] >> FRAC_BITS);
            r_q2[3]    <= r_q2[2];
            r_nrm <= NRW'(r_sq1[0]) + NRW'(r_sq1[1]) + NRW'(r_sq1[2]);
            r_lim <= (LMW'(r_sin2) * LMW'(r_nrm)) >> FRAC_BITS;
            r_ql[4] <= n_ql;
            for (int s = 5; s <= NDIV + 1; s++) begin
                r_ql[s] <= r_ql[s-1];
            end
            r_any   <= n_any;
            r_best  <= n_best;
            r_small <= r_sm[NDIV+1];
            if (r_small || !r_any) begin
                r_out <= '0;
                r_deg <= 1'b1;
            end else begin
                r_out <= n_sum[STEP_W] ? '1 : n_sum[STEP_W-1:0];
                r_deg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire
